// ===== hdl/mmcq_pkg.sv =====
package mmcq_pkg;

  localparam int QUEUE_CAP_DEF = 64;
  localparam int HITS_W        = 8;
  localparam int DELTA_W       = 16;
  localparam int ACC_W         = 32;
  localparam int CMDQ_DEPTH    = 2;
  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_PTR_W    = 2;
  localparam int OUTQ_LVL_W    = 3;

  localparam logic [HITS_W-1:0] HITS_RESET = 8'd10;

  typedef enum logic {
    CMD_MOVE = 1'b0,
    CMD_PUMP = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
  } cmd_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic                    last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_DRAIN
  } back_state_t;

endpackage

// ===== hdl/mmcq_front.sv =====
module mmcq_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_func,
  input  logic signed [mmcq_pkg::DELTA_W-1:0] in_delta_x,
  input  logic signed [mmcq_pkg::DELTA_W-1:0] in_delta_y,
  output logic                                cmd_valid,
  output mmcq_pkg::cmd_t                      cmd,
  input  logic                                cmd_pop
);
  import mmcq_pkg::*;

  cmd_t       slot_r [CMDQ_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;
  cmd_t       in_cmd;

  assign in_full   = (cnt_r == 2'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    in_cmd.kind = in_func ? CMD_PUMP : CMD_MOVE;
    in_cmd.dx   = in_delta_x;
    in_cmd.dy   = in_delta_y;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ===== hdl/mmcq_back.sv =====
module mmcq_back #(
  parameter int QUEUE_CAP = mmcq_pkg::QUEUE_CAP_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mmcq_pkg::HITS_W-1:0]           cfg_data,
  input  logic                                  cmd_valid,
  input  mmcq_pkg::cmd_t                        cmd,
  output logic                                  cmd_pop,
  input  logic [mmcq_pkg::OUTQ_LVL_W-1:0]       out_level,
  output logic                                  res_push,
  output mmcq_pkg::result_t                     res
);
  import mmcq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_CAP);
  localparam int CNT_W = $clog2(QUEUE_CAP + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int DROP  = QUEUE_CAP / 4;

  back_state_t             state_r, state_nxt;
  logic [HITS_W-1:0]       thr_r;
  logic [ACC_W-1:0]        acc_x_r, acc_x_nxt;
  logic [ACC_W-1:0]        acc_y_r, acc_y_nxt;
  logic [HITS_W-1:0]       hit_r, hit_nxt, hit_inc;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    pump_r, pump_nxt;
  logic                    rd_valid_r;
  logic                    rd_last_r;
  logic [2*ACC_W-1:0]      rd_data_r;
  logic [2*ACC_W-1:0]      mem [QUEUE_CAP];

  logic                    is_move;
  logic                    is_pump;
  logic                    mem_we;
  logic                    rd_issue;
  logic                    acc_nz;
  logic [CNT_W-1:0]        cnt_after;
  logic                    over_cap;
  logic [CNT_W-1:0]        cnt_flush;
  logic [IDX_W-1:0]        head_flush;
  logic [SUM_W-1:0]        wr_sum;
  logic [IDX_W-1:0]        wr_idx;
  logic [SUM_W-1:0]        drop_sum;
  logic [IDX_W-1:0]        head_drop;
  logic [SUM_W-1:0]        inc_sum;
  logic [IDX_W-1:0]        head_inc;
  logic [OUTQ_LVL_W:0]     out_used;

  // datapath terms
  always_comb begin
    is_move = cmd_valid && (cmd.kind == CMD_MOVE);
    is_pump = cmd_valid && (cmd.kind == CMD_PUMP);
    hit_inc = hit_r + 8'd1;
    acc_nz  = (acc_x_r != '0) || (acc_y_r != '0);

    wr_sum  = SUM_W'(head_r) + SUM_W'(count_r);
    wr_idx  = (wr_sum >= SUM_W'(QUEUE_CAP)) ? IDX_W'(wr_sum - SUM_W'(QUEUE_CAP))
                                            : IDX_W'(wr_sum);
    drop_sum  = SUM_W'(head_r) + SUM_W'(DROP);
    head_drop = (drop_sum >= SUM_W'(QUEUE_CAP)) ? IDX_W'(drop_sum - SUM_W'(QUEUE_CAP))
                                                : IDX_W'(drop_sum);
    inc_sum   = SUM_W'(head_r) + SUM_W'(1);
    head_inc  = (inc_sum >= SUM_W'(QUEUE_CAP)) ? IDX_W'(inc_sum - SUM_W'(QUEUE_CAP))
                                               : IDX_W'(inc_sum);

    cnt_after  = count_r + CNT_W'(acc_nz);
    over_cap   = (cnt_after >= CNT_W'(QUEUE_CAP));
    // drop the oldest quarter once the ring fills
    cnt_flush  = over_cap ? CNT_W'(QUEUE_CAP - DROP) : cnt_after;
    head_flush = over_cap ? head_drop : head_r;

    out_used = (OUTQ_LVL_W+1)'(out_level) + (OUTQ_LVL_W+1)'(rd_valid_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_pump || (is_move && (hit_inc >= thr_r))) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = (pump_r && (cnt_flush != '0)) ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (rd_issue && (count_r == CNT_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controls and register updates
  always_comb begin
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    rd_issue  = 1'b0;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    hit_nxt   = hit_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    pump_nxt  = pump_r;
    case (state_r)
      ST_IDLE: begin
        cmd_pop  = cmd_valid;
        pump_nxt = is_pump;
        if (is_move) begin
          acc_x_nxt = acc_x_r + ACC_W'(cmd.dx);
          acc_y_nxt = acc_y_r + ACC_W'(cmd.dy);
          hit_nxt   = hit_inc;
        end
      end
      ST_FLUSH: begin
        mem_we    = acc_nz;
        acc_x_nxt = '0;
        acc_y_nxt = '0;
        hit_nxt   = '0;
        head_nxt  = head_flush;
        count_nxt = cnt_flush;
      end
      ST_DRAIN: begin
        // hold while the output queue has no room for one more in flight
        rd_issue = (count_r != '0) && (out_used < (OUTQ_LVL_W+1)'(OUTQ_DEPTH));
        if (rd_issue) begin
          head_nxt  = head_inc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      thr_r      <= HITS_RESET;
      acc_x_r    <= '0;
      acc_y_r    <= '0;
      hit_r      <= '0;
      head_r     <= '0;
      count_r    <= '0;
      pump_r     <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      acc_x_r    <= acc_x_nxt;
      acc_y_r    <= acc_y_nxt;
      hit_r      <= hit_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      pump_r     <= pump_nxt;
      rd_valid_r <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= {acc_y_r, acc_x_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data_r <= mem[head_r];
      rd_last_r <= (count_r == CNT_W'(1));
    end
  end

  always_comb begin
    res_push = rd_valid_r;
    res.x    = rd_data_r[ACC_W-1:0];
    res.y    = rd_data_r[2*ACC_W-1:ACC_W];
    res.last = rd_last_r;
  end

endmodule

// ===== hdl/mmcq_outq.sv =====
module mmcq_outq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  mmcq_pkg::result_t               din,
  output logic [mmcq_pkg::OUTQ_LVL_W-1:0] level,
  output logic                            empty,
  input  logic                            pop,
  output mmcq_pkg::result_t               dout
);
  import mmcq_pkg::*;

  result_t               slot_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_LVL_W-1:0] cnt_r, cnt_nxt;
  logic                  do_pop;

  assign level  = cnt_r;
  assign empty  = (cnt_r == '0);
  assign dout   = slot_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OUTQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + OUTQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + OUTQ_LVL_W'(push) - OUTQ_LVL_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hdl/mouse_motion_coalescing_queue.sv =====
// Move item: accumulated into the running sums by the back part; when the hit count
// reaches the threshold it flushes and writes any nonzero sums to the ring; no result.
// Pump item: taken in idle, flushed, then one event per cycle while the output queue has
// room; drain holds with 4 results queued or in flight.
// Synchronous active-low reset clears queues, accumulators and ring pointers,
// sets the threshold to 10; the event memory itself is not cleared.
module mouse_motion_coalescing_queue #(
  parameter int QUEUE_CAP = mmcq_pkg::QUEUE_CAP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_func,
  input  logic signed [mmcq_pkg::DELTA_W-1:0] in_delta_x,
  input  logic signed [mmcq_pkg::DELTA_W-1:0] in_delta_y,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [mmcq_pkg::ACC_W-1:0]   out_move_x,
  output logic signed [mmcq_pkg::ACC_W-1:0]   out_move_y,
  output logic                                out_last_of_run,
  input  logic                                cfg_we,
  input  logic [mmcq_pkg::HITS_W-1:0]         cfg_data
);
  import mmcq_pkg::*;

  logic                  cmd_valid;
  cmd_t                  cmd;
  logic                  cmd_pop;
  logic [OUTQ_LVL_W-1:0] out_level;
  logic                  res_push;
  result_t               res;
  result_t               head_res;

  mmcq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_func    (in_func),
    .in_delta_x (in_delta_x),
    .in_delta_y (in_delta_y),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  mmcq_back #(
    .QUEUE_CAP (QUEUE_CAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_level (out_level),
    .res_push  (res_push),
    .res       (res)
  );

  mmcq_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .level (out_level),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (head_res)
  );

  assign out_move_x      = head_res.x;
  assign out_move_y      = head_res.y;
  assign out_last_of_run = head_res.last;

endmodule

// ===== hdl/mmcq_checker.sv =====
module mmcq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_push,
  input logic                                in_full,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic signed [mmcq_pkg::ACC_W-1:0]   out_move_x,
  input logic signed [mmcq_pkg::ACC_W-1:0]   out_move_y,
  input logic                                out_last_of_run
);

  a_reset_out_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reset_in_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("waiting result withdrawn");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=>
      $stable(out_move_x) && $stable(out_move_y) && $stable(out_last_of_run))
    else $error("waiting result changed");

endmodule

bind mouse_motion_coalescing_queue mmcq_checker u_chk (.*);

// ===== bench/tb_mouse_motion_coalescing_queue.sv =====
`timescale 1ns / 100ps

module tb_mouse_motion_coalescing_queue;
  import mmcq_pkg::*;

  localparam int QCAP        = QUEUE_CAP_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
  } motion_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_func = 1'b0;
  logic [DELTA_W-1:0] in_delta_x = '0;
  logic [DELTA_W-1:0] in_delta_y = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [ACC_W-1:0]   out_move_x;
  logic [ACC_W-1:0]   out_move_y;
  logic               out_last_of_run;
  logic               cfg_we = 1'b0;
  logic [HITS_W-1:0]  cfg_data = '0;

  // motion model state
  logic [ACC_W-1:0]   sum_x = '0;
  logic [ACC_W-1:0]   sum_y = '0;
  logic [HITS_W-1:0]  hit_total = '0;
  logic [HITS_W-1:0]  flush_at = HITS_RESET;
  motion_t            queued_moves[$];
  result_t            due_reports[$];
  result_t            head_report;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  mouse_motion_coalescing_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_delta_x      (in_delta_x),
    .in_delta_y      (in_delta_y),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_move_x      (out_move_x),
    .out_move_y      (out_move_y),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_mouse_motion_coalescing_queue failed");
      $finish;
    end
  end

  // receiver: long hold-off first, else random stall
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string what, input logic [ACC_W-1:0] want,
                             input logic [ACC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && !out_empty && out_pop) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual x=%h y=%h last=%b",
                 $time, out_move_x, out_move_y, out_last_of_run);
        mismatch_count++;
      end else begin
        head_report = due_reports.pop_front();
        check_field("move_x", head_report.x, out_move_x);
        check_field("move_y", head_report.y, out_move_y);
        check_field("last_of_run", ACC_W'(head_report.last), ACC_W'(out_last_of_run));
      end
    end
  end

  task automatic flush_sums();
    if (sum_x != '0 || sum_y != '0)
      queued_moves.push_back('{sum_x, sum_y});
    sum_x = '0;
    sum_y = '0;
    hit_total = '0;
    // drop the oldest quarter once the ring is full
    if (queued_moves.size() >= QCAP)
      repeat (QCAP / 4) void'(queued_moves.pop_front());
  endtask

  task automatic model_item(input cmd_kind_t kind, input logic [DELTA_W-1:0] dx,
                            input logic [DELTA_W-1:0] dy);
    motion_t mv;
    result_t rpt;
    if (kind == CMD_MOVE) begin
      sum_x = sum_x + {{(ACC_W-DELTA_W){dx[DELTA_W-1]}}, dx};
      sum_y = sum_y + {{(ACC_W-DELTA_W){dy[DELTA_W-1]}}, dy};
      hit_total = hit_total + 1'b1;
      if (hit_total >= flush_at)
        flush_sums();
    end else begin
      flush_sums();
      while (queued_moves.size() > 0) begin
        mv = queued_moves.pop_front();
        rpt.x = mv.x;
        rpt.y = mv.y;
        rpt.last = (queued_moves.size() == 0);
        due_reports.push_back(rpt);
      end
    end
  endtask

  // call at a rising edge; returns once the item was taken and any random idle gap has passed
  task automatic push_motion(input cmd_kind_t kind, input logic [DELTA_W-1:0] dx,
                             input logic [DELTA_W-1:0] dy);
    int gap;
    in_push <= 1'b1;
    in_func <= kind;
    in_delta_x <= dx;
    in_delta_y <= dy;
    @(posedge clk);
    while (in_full) @(posedge clk);
    model_item(kind, dx, dy);
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    in_push <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    // moves give no result; let the pipeline settle
    repeat (16) @(posedge clk);
  endtask

  task automatic write_flush_threshold(input logic [HITS_W-1:0] value);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    flush_at = value;
  endtask

  task automatic set_traffic(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic [DELTA_W-1:0] pick_delta();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: pick_delta = 16'h8000;
      1: pick_delta = 16'h7FFF;
      2: pick_delta = 16'h0000;
      3: pick_delta = 16'hFFFF;
      4: pick_delta = 16'($urandom_range(0, 40)) - 16'd20;
      default: pick_delta = r[DELTA_W-1:0];
    endcase
  endfunction

  function automatic logic [DELTA_W-1:0] pick_nonzero_delta();
    logic [DELTA_W-1:0] d;
    d = pick_delta();
    pick_nonzero_delta = (d == '0) ? 16'h0001 : d;
  endfunction

  task automatic run_mixed(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 9)
        push_motion(CMD_PUMP, pick_delta(), pick_delta());
      else
        push_motion(CMD_MOVE, pick_delta(), pick_delta());
    end
  endtask

  task automatic test_extremes_at_reset();
    // reset threshold of ten: tenth move flushes
    push_motion(CMD_MOVE, 16'h7FFF, 16'h8000);
    push_motion(CMD_MOVE, 16'h8000, 16'h7FFF);
    push_motion(CMD_MOVE, 16'h7FFF, 16'h7FFF);
    push_motion(CMD_MOVE, 16'h8000, 16'h8000);
    push_motion(CMD_MOVE, 16'h0000, 16'hFFFF);
    push_motion(CMD_MOVE, 16'hFFFF, 16'h0000);
    push_motion(CMD_MOVE, 16'h0001, 16'h0001);
    push_motion(CMD_MOVE, 16'h7FFF, 16'h8000);
    push_motion(CMD_MOVE, 16'h8000, 16'h7FFF);
    push_motion(CMD_MOVE, 16'h5555, 16'hAAAA);
    // pump deltas are ignored
    push_motion(CMD_PUMP, 16'hFFFF, 16'hFFFF);
    push_motion(CMD_PUMP, 16'h8000, 16'h7FFF);
  endtask

  task automatic test_zero_sum_and_thresholds();
    write_flush_threshold(8'd2);
    push_motion(CMD_MOVE, 16'h0005, 16'hFFF9);
    push_motion(CMD_MOVE, 16'hFFFB, 16'h0007);
    push_motion(CMD_PUMP, 16'h1234, 16'hABCD);
    write_flush_threshold(8'd0);
    push_motion(CMD_MOVE, 16'h0003, 16'h0004);
    push_motion(CMD_MOVE, 16'h8000, 16'h7FFF);
    push_motion(CMD_PUMP, 16'h0000, 16'h0000);
    write_flush_threshold(8'd200);
    repeat (5) push_motion(CMD_MOVE, pick_nonzero_delta(), pick_delta());
    // lower the threshold under the pending count: next move flushes
    write_flush_threshold(8'd3);
    push_motion(CMD_MOVE, 16'h0010, 16'hFFF0);
    push_motion(CMD_PUMP, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_phases();
    write_flush_threshold(8'd10);
    set_traffic(0, 0);
    run_mixed(70);
    write_flush_threshold(8'd1);
    set_traffic(77, 0);
    run_mixed(70);
    write_flush_threshold(8'd255);
    set_traffic(0, 77);
    run_mixed(70);
    write_flush_threshold(8'($urandom_range(2, 20)));
    set_traffic(16, 16);
    run_mixed(70);
    push_motion(CMD_PUMP, pick_delta(), pick_delta());
  endtask

  task automatic test_queue_overflow();
    write_flush_threshold(8'd1);
    set_traffic(16, 16);
    // fill to capacity, drop a quarter, then refill to one short of full
    repeat (QCAP + QCAP / 4 - 1)
      push_motion(CMD_MOVE, pick_nonzero_delta(), pick_delta());
    push_motion(CMD_PUMP, pick_delta(), pick_delta());
  endtask

  task automatic test_backpressure();
    write_flush_threshold(8'd1);
    set_traffic(0, 0);
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 3)
        push_motion(CMD_PUMP, pick_delta(), pick_delta());
      else
        push_motion(CMD_MOVE, pick_nonzero_delta(), pick_delta());
    end
    wait_quiet();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes_at_reset();
    test_zero_sum_and_thresholds();
    test_random_phases();
    test_queue_overflow();
    test_backpressure();
    wait_quiet();
    if (mismatch_count == 0 && due_reports.size() == 0)
      $display("tb_mouse_motion_coalescing_queue passed");
    else
      $display("tb_mouse_motion_coalescing_queue failed");
    $finish;
  end

endmodule
